// ----- rtl/ffn_pkg.sv -----
// ----------------------------------------------------------------------------
// ffn_pkg
// Shared constants, request codes and state types of the face normal block.
// ----------------------------------------------------------------------------
package ffn_pkg;

  localparam int DEF_VERTEX_DEPTH = 4096;
  localparam int DEF_COORD_WIDTH  = 24;
  localparam int INDEX_WIDTH      = 12;
  localparam int NORMAL_WIDTH     = 16;
  localparam int MAG_WIDTH        = 31;
  localparam int SUM_WIDTH        = 64;
  localparam int ROOT_STEPS       = 32;
  localparam int ROOT_WIDTH       = 32;
  localparam int QUOT_WIDTH       = 17;
  localparam int FRAC_SHIFT       = 16;
  localparam int QUEUE_DEPTH      = 2;
  localparam int MUL_STEPS        = 6;
  localparam int SQ_PASSES        = 3;

  typedef enum logic {
    REQ_VERTEX = 1'b0,
    REQ_FACE   = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_RD_B,
    F_RD_C,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_EDGE,
    B_MUL,
    B_MAG,
    B_NORM,
    B_SQ,
    B_SQRT,
    B_DIV,
    B_FIN
  } back_state_t;

endpackage

// ----- rtl/ffn_ram.sv -----
// ----------------------------------------------------------------------------
// ffn_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module ffn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/ffn_queue.sv -----
// ----------------------------------------------------------------------------
// ffn_queue
// Short job queue between the vertex fetch front and the arithmetic back end.
// ----------------------------------------------------------------------------
module ffn_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  import ffn_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

// ----- rtl/ffn_front.sv -----
// ----------------------------------------------------------------------------
// ffn_front
// Accepts beats, writes vertices and fetches the three corners of a face.
// ----------------------------------------------------------------------------
module ffn_front #(
  parameter int VERTEX_DEPTH = ffn_pkg::DEF_VERTEX_DEPTH,
  parameter int COORD_WIDTH  = ffn_pkg::DEF_COORD_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             req_type,
  input  logic [ffn_pkg::INDEX_WIDTH-1:0]  vertex_slot,
  input  logic signed [COORD_WIDTH-1:0]    coord_x,
  input  logic signed [COORD_WIDTH-1:0]    coord_y,
  input  logic signed [COORD_WIDTH-1:0]    coord_z,
  input  logic [ffn_pkg::INDEX_WIDTH-1:0]  corner_first,
  input  logic [ffn_pkg::INDEX_WIDTH-1:0]  corner_second,
  input  logic [ffn_pkg::INDEX_WIDTH-1:0]  corner_third,
  input  logic                             last_face,
  input  logic                             q_full,
  output logic                             busy,
  output logic                             push,
  output logic [9*COORD_WIDTH:0]           job
);
  import ffn_pkg::*;

  localparam int AW = $clog2(VERTEX_DEPTH);
  localparam int VW = 3 * COORD_WIDTH;

  function automatic logic [AW-1:0] wrap_index(input logic [INDEX_WIDTH-1:0] idx);
    logic [INDEX_WIDTH-1:0] r;
    r = idx;
    for (int k = INDEX_WIDTH - 1; k >= 0; k--) begin
      if (32'(r) >= (VERTEX_DEPTH << k)) begin
        r = r - INDEX_WIDTH'(VERTEX_DEPTH << k);
      end
    end
    return AW'(r);
  endfunction

  front_state_t   state;
  front_state_t   state_next;
  logic [AW-1:0]  idx_b;
  logic [AW-1:0]  idx_c;
  logic           last;
  logic [VW-1:0]  p0;
  logic [VW-1:0]  p1;
  logic           ram_en;
  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [VW-1:0]  ram_rdata;

  ffn_ram #(
    .WIDTH (VW),
    .DEPTH (VERTEX_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({coord_z, coord_y, coord_x}),
    .rdata (ram_rdata)
  );

  assign busy = (state != F_IDLE);
  assign job  = {last, ram_rdata, p1, p0};

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (start && req_type == REQ_FACE) begin
          state_next = F_RD_B;
        end
      end
      F_RD_B: state_next = F_RD_C;
      F_RD_C: state_next = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = wrap_index(corner_first);
    push     = 1'b0;
    unique case (state)
      F_IDLE: begin
        ram_en   = start;
        ram_we   = start && (req_type == REQ_VERTEX);
        ram_addr = (req_type == REQ_VERTEX) ? wrap_index(vertex_slot)
                                            : wrap_index(corner_first);
      end
      F_RD_B: begin
        ram_en   = 1'b1;
        ram_addr = idx_b;
      end
      F_RD_C: begin
        ram_en   = 1'b1;
        ram_addr = idx_c;
      end
      F_PUSH: push = !q_full;
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      idx_b <= wrap_index(corner_second);
      idx_c <= wrap_index(corner_third);
      last  <= last_face;
    end
    if (state == F_RD_B) begin
      p0 <= ram_rdata;
    end
    if (state == F_RD_C) begin
      p1 <= ram_rdata;
    end
  end

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == F_IDLE)
    else $error("vertex store written while a face fetch is in progress");

  a_push_done: assert property (@(posedge clk) disable iff (rst)
    push |=> state == F_IDLE)
    else $error("front did not return to idle after handing over a job");

endmodule

// ----- rtl/ffn_back.sv -----
// ----------------------------------------------------------------------------
// ffn_back
// Edge vectors, cross product and unit-length normalization of one face.
// ----------------------------------------------------------------------------
module ffn_back #(
  parameter int COORD_WIDTH = ffn_pkg::DEF_COORD_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    empty,
  input  logic [9*COORD_WIDTH:0]                  job,
  output logic                                    pop,
  output logic                                    strobe,
  output logic signed [ffn_pkg::NORMAL_WIDTH-1:0] normal_x,
  output logic signed [ffn_pkg::NORMAL_WIDTH-1:0] normal_y,
  output logic signed [ffn_pkg::NORMAL_WIDTH-1:0] normal_z,
  output logic                                    degenerate,
  output logic                                    last_normal
);
  import ffn_pkg::*;

  localparam int VW   = 3 * COORD_WIDTH;
  localparam int EW   = COORD_WIDTH + 1;
  localparam int PW   = 2 * EW;
  localparam int CWD  = PW + 1;
  localparam int NW   = (CWD > MAG_WIDTH) ? CWD : MAG_WIDTH;
  localparam int DW   = FRAC_SHIFT + MAG_WIDTH + 1;
  localparam int DVW  = ROOT_WIDTH + 1;
  localparam int RW   = ROOT_WIDTH + 2;
  localparam int CNTW = $clog2(ROOT_STEPS + 1);
  localparam int QMAX = 2 ** (NORMAL_WIDTH - 1) - 1;

  back_state_t st;
  back_state_t st_next;
  logic [CNTW-1:0] cnt;

  logic signed [COORD_WIDTH-1:0] pa [3];
  logic signed [COORD_WIDTH-1:0] pb [3];
  logic signed [COORD_WIDTH-1:0] pc [3];
  logic signed [EW-1:0]          ea [3];
  logic signed [EW-1:0]          eb [3];
  logic signed [EW-1:0]          mul_a;
  logic signed [EW-1:0]          mul_b;
  logic signed [PW-1:0]          prod;
  logic signed [CWD-1:0]         c [3];
  logic [CWD-1:0]                cabs [3];
  logic                          negc [3];
  logic [NW-1:0]                 nm [3];
  logic [NW-1:0]                 orv;
  logic [MAG_WIDTH-1:0]          mag [3];
  logic [MAG_WIDTH-1:0]          sq_op;
  logic [2*MAG_WIDTH-1:0]        sqp;
  logic [SUM_WIDTH-1:0]          sum;
  logic [SUM_WIDTH-1:0]          sqv;
  logic [SUM_WIDTH-1:0]          sqres;
  logic [SUM_WIDTH-1:0]          sqbit;
  logic [SUM_WIDTH-1:0]          sqtry;
  logic [DVW-1:0]                dsor;
  logic [DW-1:0]                 num [3];
  logic [RW-1:0]                 rem [3];
  logic [RW-1:0]                 trial [3];
  logic [QUOT_WIDTH-1:0]         nlo [3];
  logic [QUOT_WIDTH-1:0]         quo [3];
  logic [NORMAL_WIDTH-1:0]       satv [3];
  logic [NORMAL_WIDTH-1:0]       outv [3];
  logic [CNTW-1:0]               acc_sel;
  logic                          dgn;
  logic                          lastr;

  always_comb begin
    st_next = st;
    unique case (st)
      B_IDLE: begin
        if (!empty) begin
          st_next = B_EDGE;
        end
      end
      B_EDGE: st_next = B_MUL;
      B_MUL: begin
        if (cnt == CNTW'(MUL_STEPS)) begin
          st_next = B_MAG;
        end
      end
      B_MAG: st_next = B_NORM;
      B_NORM: begin
        if (orv == '0) begin
          st_next = B_FIN;
        end else if (orv[NW-1]) begin
          st_next = B_SQ;
        end
      end
      B_SQ: begin
        if (cnt == CNTW'(SQ_PASSES)) begin
          st_next = B_SQRT;
        end
      end
      B_SQRT: begin
        if (cnt == CNTW'(ROOT_STEPS - 1)) begin
          st_next = B_DIV;
        end
      end
      B_DIV: begin
        if (cnt == CNTW'(QUOT_WIDTH)) begin
          st_next = B_FIN;
        end
      end
      B_FIN: st_next = B_IDLE;
      default: st_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    unique case (st)
      B_IDLE:  pop = !empty;
      default: pop = 1'b0;
    endcase
  end

  always_comb begin
    case (cnt[2:0])
      3'd0: begin mul_a = ea[1]; mul_b = eb[2]; end
      3'd1: begin mul_a = ea[2]; mul_b = eb[1]; end
      3'd2: begin mul_a = ea[2]; mul_b = eb[0]; end
      3'd3: begin mul_a = ea[0]; mul_b = eb[2]; end
      3'd4: begin mul_a = ea[0]; mul_b = eb[1]; end
      default: begin mul_a = ea[1]; mul_b = eb[0]; end
    endcase
    acc_sel = cnt - 1'b1;
    orv     = nm[0] | nm[1] | nm[2];
    for (int j = 0; j < 3; j++) begin
      cabs[j]  = c[j][CWD-1] ? CWD'(-c[j]) : CWD'(c[j]);
      mag[j]   = nm[j][NW-1 -: MAG_WIDTH];
      num[j]   = DW'({mag[j], FRAC_SHIFT'(0)}) + DW'(sqres[ROOT_WIDTH-1:0]);
      trial[j] = {rem[j][RW-2:0], nlo[j][QUOT_WIDTH-1]};
      satv[j]  = (quo[j] > QUOT_WIDTH'(QMAX)) ? NORMAL_WIDTH'(QMAX)
                                               : quo[j][NORMAL_WIDTH-1:0];
      outv[j]  = dgn ? '0 : (negc[j] ? -satv[j] : satv[j]);
    end
    case (cnt[1:0])
      2'd0:    sq_op = mag[0];
      2'd1:    sq_op = mag[1];
      default: sq_op = mag[2];
    endcase
    sqtry = sqres + sqbit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= B_IDLE;
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      st     <= st_next;
      cnt    <= (st_next != st) ? '0 : cnt + 1'b1;
      strobe <= (st == B_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      B_IDLE: begin
        if (pop) begin
          for (int j = 0; j < 3; j++) begin
            pa[j] <= job[j*COORD_WIDTH +: COORD_WIDTH];
            pb[j] <= job[VW + j*COORD_WIDTH +: COORD_WIDTH];
            pc[j] <= job[2*VW + j*COORD_WIDTH +: COORD_WIDTH];
          end
          lastr <= job[3*VW];
        end
      end
      B_EDGE: begin
        for (int j = 0; j < 3; j++) begin
          ea[j] <= EW'(pc[j]) - EW'(pa[j]);
          eb[j] <= EW'(pb[j]) - EW'(pa[j]);
          c[j]  <= '0;
        end
      end
      B_MUL: begin
        if (cnt < CNTW'(MUL_STEPS)) begin
          prod <= mul_a * mul_b;
        end
        for (int j = 0; j < 3; j++) begin
          if (cnt != '0 && acc_sel[2:1] == 2'(j)) begin
            c[j] <= acc_sel[0] ? c[j] - CWD'(prod) : c[j] + CWD'(prod);
          end
        end
      end
      B_MAG: begin
        for (int j = 0; j < 3; j++) begin
          negc[j] <= c[j][CWD-1];
          nm[j]   <= NW'(cabs[j]);
        end
      end
      B_NORM: begin
        dgn <= (orv == '0);
        sum <= '0;
        if (orv != '0 && !orv[NW-1]) begin
          for (int j = 0; j < 3; j++) begin
            nm[j] <= (orv[NW-1 -: 8] == '0) ? nm[j] << 8 : nm[j] << 1;
          end
        end
      end
      B_SQ: begin
        if (cnt < CNTW'(SQ_PASSES)) begin
          sqp <= sq_op * sq_op;
        end
        if (cnt != '0) begin
          sum <= sum + SUM_WIDTH'(sqp);
        end
        if (cnt == CNTW'(SQ_PASSES)) begin
          sqv   <= sum + SUM_WIDTH'(sqp);
          sqres <= '0;
          sqbit <= SUM_WIDTH'(1) << (SUM_WIDTH - 2);
        end
      end
      B_SQRT: begin
        if (sqv >= sqtry) begin
          sqv   <= sqv - sqtry;
          sqres <= (sqres >> 1) + sqbit;
        end else begin
          sqres <= sqres >> 1;
        end
        sqbit <= sqbit >> 2;
      end
      B_DIV: begin
        if (cnt == '0) begin
          dsor <= {sqres[ROOT_WIDTH-1:0], 1'b0};
          for (int j = 0; j < 3; j++) begin
            rem[j] <= RW'(num[j] >> QUOT_WIDTH);
            nlo[j] <= num[j][QUOT_WIDTH-1:0];
            quo[j] <= '0;
          end
        end else begin
          for (int j = 0; j < 3; j++) begin
            nlo[j] <= nlo[j] << 1;
            if (trial[j] >= RW'(dsor)) begin
              rem[j] <= trial[j] - RW'(dsor);
              quo[j] <= {quo[j][QUOT_WIDTH-2:0], 1'b1};
            end else begin
              rem[j] <= trial[j];
              quo[j] <= {quo[j][QUOT_WIDTH-2:0], 1'b0};
            end
          end
        end
      end
      B_FIN: begin
        normal_x    <= outv[0];
        normal_y    <= outv[1];
        normal_z    <= outv[2];
        degenerate  <= dgn;
        last_normal <= lastr;
      end
      default: begin
      end
    endcase
  end

  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("result strobe held for more than one cycle");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("degenerate face produced a nonzero normal");

  a_pop_start: assert property (@(posedge clk) disable iff (rst)
    pop |=> st == B_EDGE)
    else $error("job taken from the queue without starting the edge stage");

endmodule

// ----- rtl/flat_face_normal.sv -----
// ----------------------------------------------------------------------------
// flat_face_normal
// Vertex store and unit face normal of a flat triangle in signed Q1.15.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. A vertex write leaves
// busy low. After a face beat, the three corners are read one after another
// from the single-port vertex store, and busy stays high until the job is
// pushed; it stays high longer while the queue is full. The job then waits in
// a two-entry queue for the arithmetic back end. The back end works on one
// face at a time: one shared multiplier forms the cross product, and the
// magnitudes are normalized one or eight bits a cycle. The squared length, the
// square root and the three parallel dividers follow in turn. A degenerate
// face skips the squared length, the square root and the division. The back
// end takes a new face only when it is through with the last one, and that
// loop sets the sustained face rate. Each result appears for exactly one cycle
// with strobe high and cannot be held off by the receiver. Reading a vertex
// that was never written gives an undefined normal.
module flat_face_normal #(
  parameter int VERTEX_DEPTH = ffn_pkg::DEF_VERTEX_DEPTH,
  parameter int COORD_WIDTH  = ffn_pkg::DEF_COORD_WIDTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    req_type,
  input  logic [ffn_pkg::INDEX_WIDTH-1:0]         vertex_slot,
  input  logic signed [COORD_WIDTH-1:0]           coord_x,
  input  logic signed [COORD_WIDTH-1:0]           coord_y,
  input  logic signed [COORD_WIDTH-1:0]           coord_z,
  input  logic [ffn_pkg::INDEX_WIDTH-1:0]         corner_first,
  input  logic [ffn_pkg::INDEX_WIDTH-1:0]         corner_second,
  input  logic [ffn_pkg::INDEX_WIDTH-1:0]         corner_third,
  input  logic                                    last_face,
  output logic                                    strobe,
  output logic signed [ffn_pkg::NORMAL_WIDTH-1:0] normal_x,
  output logic signed [ffn_pkg::NORMAL_WIDTH-1:0] normal_y,
  output logic signed [ffn_pkg::NORMAL_WIDTH-1:0] normal_z,
  output logic                                    degenerate,
  output logic                                    last_normal
);
  import ffn_pkg::*;

  localparam int JW = 9 * COORD_WIDTH + 1;

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [JW-1:0] q_wdata;
  logic [JW-1:0] q_rdata;

  ffn_front #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .req_type      (req_type),
    .vertex_slot   (vertex_slot),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .coord_z       (coord_z),
    .corner_first  (corner_first),
    .corner_second (corner_second),
    .corner_third  (corner_third),
    .last_face     (last_face),
    .q_full        (q_full),
    .busy          (busy),
    .push          (q_push),
    .job           (q_wdata)
  );

  ffn_queue #(
    .WIDTH (JW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  ffn_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (q_empty),
    .job         (q_rdata),
    .pop         (q_pop),
    .strobe      (strobe),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .degenerate  (degenerate),
    .last_normal (last_normal)
  );

endmodule
